@@ rtl/fjop_pkg.sv @@
// ----------------------------------------------------------------------------
// fjop_pkg
// types, codes and constants shared by the flat json object parser
// ----------------------------------------------------------------------------
`default_nettype none

package fjop_pkg;

  // longest key, string or number is MaxText - 1 characters
  localparam int unsigned MaxText = 100;
  localparam int unsigned LenW    = 7;
  localparam int unsigned NumW    = 31;

  localparam logic [NumW-1:0] NumMax = {NumW{1'b1}};

  localparam logic [7:0] ChOpen  = 8'h7B;  // {
  localparam logic [7:0] ChClose = 8'h7D;  // }
  localparam logic [7:0] ChQuote = 8'h22;  // "
  localparam logic [7:0] ChComma = 8'h2C;  // ,
  localparam logic [7:0] ChColon = 8'h3A;  // :
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic [3:0] {
    PhWaitOpen    = 4'd0,
    PhKeyOpen     = 4'd1,
    PhKey         = 4'd2,
    PhColon       = 4'd3,
    PhValueStart  = 4'd4,
    PhNumber      = 4'd5,
    PhString      = 4'd6,
    PhAfterValue  = 4'd7,
    PhClosed      = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    EvNone       = 3'd0,
    EvKeyChar    = 3'd1,
    EvStrChar    = 3'd2,
    EvKeyEnd     = 3'd3,
    EvNumDone    = 3'd4,
    EvStrDone    = 3'd5,
    EvObjDone    = 3'd6,
    EvError      = 3'd7
  } event_e;

  typedef enum logic [3:0] {
    ErrNone       = 4'd0,
    ErrEmpty      = 4'd1,
    ErrNoOpen     = 4'd2,
    ErrNoKeyQuote = 4'd3,
    ErrNoColon    = 4'd4,
    ErrBadDigit   = 4'd5,
    ErrEarlyEnd   = 4'd6,
    ErrNoClose    = 4'd7,
    ErrTrailing   = 4'd8,
    ErrTooLong    = 4'd9
  } err_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    event_e          event_res;
    logic [7:0]      char_out;
    logic [NumW-1:0] number_value;
    err_e            error_code;
    logic            last;
  } out_beat_t;

endpackage

`default_nettype wire

@@ rtl/flat_json_object_parser.sv @@
// ----------------------------------------------------------------------------
// flat_json_object_parser: one result beat per text byte of a flat json object
// result registered as its byte is taken; 1 byte per cycle unless the output
// stalls; a parse step (phase decode plus a saturating acc*10+digit) per byte
// async active-low reset returns to waiting for the open brace, no error
// ----------------------------------------------------------------------------
`default_nettype none

module flat_json_object_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire fjop_pkg::in_beat_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output fjop_pkg::out_beat_t     out_data_o
);

  // parse state
  fjop_pkg::phase_e              phase_q, phase_d, phase_nx;
  logic [fjop_pkg::NumW-1:0]     acc_q, acc_d;
  logic [fjop_pkg::LenW-1:0]     len_q, len_d;
  logic                          err_q, err_d;
  logic                          started_q, started_d;

  // result register
  logic                          out_valid_q;
  fjop_pkg::out_beat_t           out_data_q;
  fjop_pkg::out_beat_t           res;

  logic                          in_fire;
  logic [7:0]                    c;
  logic                          eot;
  logic                          blank, digit, len_full;
  logic [fjop_pkg::NumW+3:0]     prod;
  logic [fjop_pkg::NumW-1:0]     acc_step;

  // step outputs before the end of text override
  fjop_pkg::event_e              step_ev;
  fjop_pkg::err_e                step_err;
  logic [7:0]                    step_ch;
  logic [fjop_pkg::NumW-1:0]     step_num;

  // a new byte may enter whenever the result slot is empty or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign c   = in_data_i.text_byte;
  assign eot = in_data_i.end_of_text;

  always_comb begin
    blank = c inside {fjop_pkg::ChSpace, fjop_pkg::ChTab, fjop_pkg::ChCr, fjop_pkg::ChLf};
    digit = c inside {[fjop_pkg::ChZero:fjop_pkg::ChNine]};
  end

  assign len_full = len_q >= fjop_pkg::LenW'(fjop_pkg::MaxText - 1);

  // acc*10 + digit as two shifted copies, saturated
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
              + {{(fjop_pkg::NumW){1'b0}}, c[3:0]};
  assign acc_step = (prod > {4'b0000, fjop_pkg::NumMax}) ? fjop_pkg::NumMax
                                                          : prod[fjop_pkg::NumW-1:0];

  // step outputs: event, character, number and error raised by this byte
  always_comb begin
    step_ev  = fjop_pkg::EvNone;
    step_err = fjop_pkg::ErrNone;
    step_ch  = '0;
    step_num = '0;
    if (!err_q) begin
      case (phase_q)
        fjop_pkg::PhWaitOpen: begin
          if (c != fjop_pkg::ChOpen && !blank) step_err = fjop_pkg::ErrNoOpen;
        end
        fjop_pkg::PhKeyOpen: begin
          if (c != fjop_pkg::ChQuote && !blank) step_err = fjop_pkg::ErrNoKeyQuote;
        end
        fjop_pkg::PhKey, fjop_pkg::PhString: begin
          if (c == fjop_pkg::ChQuote) begin
            step_ev = (phase_q == fjop_pkg::PhKey) ? fjop_pkg::EvKeyEnd
                                                   : fjop_pkg::EvStrDone;
          end else if (c == fjop_pkg::ChNul) begin
            step_err = fjop_pkg::ErrEarlyEnd;
          end else if (len_full) begin
            step_err = fjop_pkg::ErrTooLong;
          end else begin
            step_ev = (phase_q == fjop_pkg::PhKey) ? fjop_pkg::EvKeyChar
                                                   : fjop_pkg::EvStrChar;
            step_ch = c;
          end
        end
        fjop_pkg::PhColon: begin
          if (c != fjop_pkg::ChColon && !blank) step_err = fjop_pkg::ErrNoColon;
        end
        fjop_pkg::PhValueStart: begin
          if (c == fjop_pkg::ChQuote || digit || blank) begin
            step_err = fjop_pkg::ErrNone;
          end else if (c == fjop_pkg::ChNul) begin
            step_err = fjop_pkg::ErrEarlyEnd;
          end else begin
            step_err = fjop_pkg::ErrBadDigit;
          end
        end
        fjop_pkg::PhNumber: begin
          if (digit) begin
            if (len_full) step_err = fjop_pkg::ErrTooLong;
          end else if (c == fjop_pkg::ChClose) begin
            step_ev  = fjop_pkg::EvObjDone;
            step_num = acc_q;
          end else if (c == fjop_pkg::ChComma || blank) begin
            step_ev  = fjop_pkg::EvNumDone;
            step_num = acc_q;
          end else if (c == fjop_pkg::ChNul) begin
            step_err = fjop_pkg::ErrEarlyEnd;
          end else begin
            step_err = fjop_pkg::ErrBadDigit;
          end
        end
        fjop_pkg::PhAfterValue: begin
          if (c == fjop_pkg::ChClose) begin
            step_ev = fjop_pkg::EvObjDone;
          end else if (c != fjop_pkg::ChComma && !blank) begin
            step_err = fjop_pkg::ErrNoClose;
          end
        end
        fjop_pkg::PhClosed: begin
          if (!blank) step_err = fjop_pkg::ErrTrailing;
        end
        default: begin
          step_err = fjop_pkg::ErrEarlyEnd;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nx  = phase_q;
    acc_d     = acc_q;
    len_d     = len_q;
    err_d     = err_q || (step_err != fjop_pkg::ErrNone);
    started_d = started_q || !blank;
    if (!err_q && step_err == fjop_pkg::ErrNone) begin
      case (phase_q)
        fjop_pkg::PhWaitOpen: begin
          if (c == fjop_pkg::ChOpen) phase_nx = fjop_pkg::PhKeyOpen;
        end
        fjop_pkg::PhKeyOpen: begin
          if (c == fjop_pkg::ChQuote) begin
            phase_nx = fjop_pkg::PhKey;
            len_d    = '0;
          end
        end
        fjop_pkg::PhKey: begin
          if (c == fjop_pkg::ChQuote) phase_nx = fjop_pkg::PhColon;
          else                        len_d    = len_q + 1'b1;
        end
        fjop_pkg::PhColon: begin
          if (c == fjop_pkg::ChColon) phase_nx = fjop_pkg::PhValueStart;
        end
        fjop_pkg::PhValueStart: begin
          if (c == fjop_pkg::ChQuote) begin
            phase_nx = fjop_pkg::PhString;
            len_d    = '0;
          end else if (digit) begin
            phase_nx = fjop_pkg::PhNumber;
            acc_d    = {{(fjop_pkg::NumW-4){1'b0}}, c[3:0]};
            len_d    = fjop_pkg::LenW'(1);
          end
        end
        fjop_pkg::PhNumber: begin
          if (digit) begin
            acc_d = acc_step;
            len_d = len_q + 1'b1;
          end else if (c == fjop_pkg::ChComma) begin
            phase_nx = fjop_pkg::PhKeyOpen;
          end else if (c == fjop_pkg::ChClose) begin
            phase_nx = fjop_pkg::PhClosed;
          end else if (blank) begin
            phase_nx = fjop_pkg::PhAfterValue;
          end
        end
        fjop_pkg::PhString: begin
          if (c == fjop_pkg::ChQuote) phase_nx = fjop_pkg::PhAfterValue;
          else                        len_d    = len_q + 1'b1;
        end
        fjop_pkg::PhAfterValue: begin
          if (c == fjop_pkg::ChComma)      phase_nx = fjop_pkg::PhKeyOpen;
          else if (c == fjop_pkg::ChClose) phase_nx = fjop_pkg::PhClosed;
        end
        default: begin
          phase_nx = phase_q;
        end
      endcase
    end
    phase_d = phase_nx;
    // the last byte of a text puts everything back to reset
    if (eot) begin
      phase_d   = fjop_pkg::PhWaitOpen;
      acc_d     = '0;
      len_d     = '0;
      err_d     = 1'b0;
      started_d = 1'b0;
    end
  end

  // result beat, with the early end or empty error taking over the last byte
  always_comb begin
    res.event_res    = step_ev;
    res.char_out     = step_ch;
    res.number_value = step_num;
    res.error_code   = step_err;
    res.last         = eot;
    if (step_err != fjop_pkg::ErrNone) begin
      res.event_res = fjop_pkg::EvError;
    end else if (eot && !err_q && phase_nx != fjop_pkg::PhClosed) begin
      res.event_res    = fjop_pkg::EvError;
      res.char_out     = '0;
      res.number_value = '0;
      res.error_code   = (started_q || !blank) ? fjop_pkg::ErrEarlyEnd
                                               : fjop_pkg::ErrEmpty;
    end
  end

  // parse state registers, advanced once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= fjop_pkg::PhWaitOpen;
      acc_q     <= '0;
      len_q     <= '0;
      err_q     <= 1'b0;
      started_q <= 1'b0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      len_q     <= len_d;
      err_q     <= err_d;
      started_q <= started_d;
    end
  end

  // result slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // the last byte always leaves the parser in its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.end_of_text |=>
      phase_q == fjop_pkg::PhWaitOpen && !err_q && !started_q && len_q == '0)
    else $error("parser not restarted after last byte");

  // a latched error holds until the text ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q && !(in_fire && in_data_i.end_of_text) |=> err_q)
    else $error("error latch dropped inside a text");

  // once an error is latched, bytes give no events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && err_q |=> out_data_o.event_res == fjop_pkg::EvNone)
    else $error("event after latched error");

  // error code present exactly on error events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((out_data_o.event_res == fjop_pkg::EvError) ==
       (out_data_o.error_code != fjop_pkg::ErrNone)))
    else $error("error code and event disagree");

  // character only on key or string character events
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res != fjop_pkg::EvKeyChar &&
    out_data_o.event_res != fjop_pkg::EvStrChar |-> out_data_o.char_out == '0)
    else $error("stray character on result");

  // key, string or number length stays under the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= fjop_pkg::LenW'(fjop_pkg::MaxText - 1))
    else $error("length counter past limit");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: flat json object parser
// feeds text bytes over a valid/ready input, one byte per beat, and checks every
// result beat against an in-bench parse predictor or a typed row; a short table
// of hand-picked texts runs first, then random objects, broken objects and noise
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fjop_pkg::*;

  // one row of the directed table; want is used only where typed is set
  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } row_t;

  localparam out_beat_t NoCheck = '{EvNone, 8'h00, {NumW{1'b0}}, ErrNone, 1'b0};
  localparam int unsigned RandBytes = 450;
  localparam int unsigned DrainText = 6;    // sender waits for all results here
  localparam int unsigned LongHoldAt = 150; // receiver stalls once after this many
  localparam int unsigned LongHold = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;

  // expected result beats, oldest first
  out_beat_t   expected_beats[$];
  // bytes of the text being sent
  logic [7:0]  text_q[$];
  bit          sender_calm = 1'b0;

  // parse state of the predictor
  phase_e          ps_phase;
  logic [NumW-1:0] ps_acc;
  logic [LenW-1:0] ps_len;
  bit              ps_err;
  bit              ps_started;

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned saturated = 0;
  int unsigned ev_seen [8];

  flat_json_object_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // parse predictor
  // --------------------------------------------------------------------------

  function automatic void clear_parse();
    ps_phase   = PhWaitOpen;
    ps_acc     = '0;
    ps_len     = '0;
    ps_err     = 1'b0;
    ps_started = 1'b0;
  endfunction

  // one more character in the current key or value; 0 when past the limit
  function automatic bit take_char();
    if (ps_len >= MaxText - 1) return 1'b0;
    ps_len = ps_len + 1'b1;
    return 1'b1;
  endfunction

  function automatic out_beat_t parse_byte(input in_beat_t b);
    out_beat_t   r;
    logic [7:0]  c;
    bit          blank;
    bit          digit;
    err_e        fault;
    logic [34:0] wide;
    c     = b.text_byte;
    blank = (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
    digit = (c >= ChZero) && (c <= ChNine);
    fault = ErrNone;
    r     = NoCheck;
    r.last = b.end_of_text;
    if (!blank) ps_started = 1'b1;

    if (!ps_err) begin
      case (ps_phase)
        PhWaitOpen: begin
          if (c == ChOpen) ps_phase = PhKeyOpen;
          else if (!blank) fault = ErrNoOpen;
        end
        PhKeyOpen: begin
          if (c == ChQuote) begin
            ps_phase = PhKey;
            ps_len   = '0;
          end else if (!blank) begin
            fault = ErrNoKeyQuote;
          end
        end
        PhKey: begin
          if (c == ChQuote) begin
            r.event_res = EvKeyEnd;
            ps_phase    = PhColon;
          end else if (c == ChNul) begin
            fault = ErrEarlyEnd;
          end else if (take_char()) begin
            r.event_res = EvKeyChar;
            r.char_out  = c;
          end else begin
            fault = ErrTooLong;
          end
        end
        PhColon: begin
          if (c == ChColon) ps_phase = PhValueStart;
          else if (!blank) fault = ErrNoColon;
        end
        PhValueStart: begin
          if (c == ChQuote) begin
            ps_phase = PhString;
            ps_len   = '0;
          end else if (digit) begin
            ps_phase = PhNumber;
            ps_acc   = {{(NumW-8){1'b0}}, c - ChZero};
            ps_len   = LenW'(1);
          end else if (c == ChNul) begin
            fault = ErrEarlyEnd;
          end else if (!blank) begin
            fault = ErrBadDigit;
          end
        end
        PhNumber: begin
          if (digit) begin
            if (take_char()) begin
              wide   = {4'd0, ps_acc} * 35'd10 + {27'd0, c - ChZero};
              ps_acc = (wide > {4'd0, NumMax}) ? NumMax : wide[NumW-1:0];
            end else begin
              fault = ErrTooLong;
            end
          end else if (c == ChComma) begin
            r.event_res    = EvNumDone;
            r.number_value = ps_acc;
            ps_phase       = PhKeyOpen;
          end else if (c == ChClose) begin
            r.event_res    = EvObjDone;
            r.number_value = ps_acc;
            ps_phase       = PhClosed;
          end else if (blank) begin
            r.event_res    = EvNumDone;
            r.number_value = ps_acc;
            ps_phase       = PhAfterValue;
          end else if (c == ChNul) begin
            fault = ErrEarlyEnd;
          end else begin
            fault = ErrBadDigit;
          end
        end
        PhString: begin
          if (c == ChQuote) begin
            r.event_res = EvStrDone;
            ps_phase    = PhAfterValue;
          end else if (c == ChNul) begin
            fault = ErrEarlyEnd;
          end else if (take_char()) begin
            r.event_res = EvStrChar;
            r.char_out  = c;
          end else begin
            fault = ErrTooLong;
          end
        end
        PhAfterValue: begin
          if (c == ChComma) begin
            ps_phase = PhKeyOpen;
          end else if (c == ChClose) begin
            r.event_res = EvObjDone;
            ps_phase    = PhClosed;
          end else if (!blank) begin
            fault = ErrNoClose;
          end
        end
        PhClosed: begin
          if (!blank) fault = ErrTrailing;
        end
        default: fault = ErrEarlyEnd;
      endcase
    end

    // text ending before the object closed replaces the byte's event, unless an error came first
    if (b.end_of_text && !ps_err && fault == ErrNone && ps_phase != PhClosed)
      fault = ps_started ? ErrEarlyEnd : ErrEmpty;

    if (fault != ErrNone) begin
      r.event_res    = EvError;
      r.char_out     = 8'h00;
      r.number_value = '0;
      r.error_code   = fault;
      ps_err         = 1'b1;
    end

    if (b.end_of_text) clear_parse();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // text generation
  // --------------------------------------------------------------------------

  // idle length for either side: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_blanks(input int unsigned lo);
    int unsigned n;
    n = $urandom_range(0, 4);
    if (n > 2) n = 0;
    if (n < lo) n = lo;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       text_q.push_back(ChSpace);
        1:       text_q.push_back(ChTab);
        2:       text_q.push_back(ChCr);
        default: text_q.push_back(ChLf);
      endcase
    end
  endfunction

  // key or string body (any byte but quote and nul), or the digits of a number
  function automatic void push_token(input bit digits);
    int unsigned n;
    logic [7:0]  c;
    if ($urandom_range(0, 29) == 0) n = $urandom_range(MaxText - 4, MaxText + 1);
    else if (digits && $urandom_range(0, 4) == 0) n = $urandom_range(10, 12);
    else n = $urandom_range(0, 4);
    if (digits && n == 0) n = 1;
    repeat (n) begin
      if (digits) begin
        c = ChZero + 8'($urandom_range(0, 9));
      end else begin
        c = 8'($urandom_range(1, 255));
        if (c == ChQuote) c = ChColon;
      end
      text_q.push_back(c);
    end
  endfunction

  // half well-formed objects with random content, the rest broken or noise
  function automatic void build_text();
    int unsigned mode;
    int unsigned members;
    int unsigned cut;
    string       edge_num;
    text_q.delete();
    mode = $urandom_range(0, 99);

    // blanks only
    if (mode < 6) begin
      add_blanks(1);
      return;
    end
    // random bytes
    if (mode < 12) begin
      repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    // empty object
    if (mode < 15) begin
      add_blanks(0);
      text_q.push_back(ChOpen);
      add_blanks(0);
      text_q.push_back(ChClose);
      return;
    end

    add_blanks(0);
    text_q.push_back(ChOpen);
    members = $urandom_range(1, 3);
    for (int m = 0; m < members; m++) begin
      if (m != 0) text_q.push_back(ChComma);
      add_blanks(0);
      text_q.push_back(ChQuote);
      push_token(1'b0);
      text_q.push_back(ChQuote);
      add_blanks(0);
      text_q.push_back(ChColon);
      add_blanks(0);
      if ($urandom_range(0, 1) == 0) begin
        text_q.push_back(ChQuote);
        push_token(1'b0);
        text_q.push_back(ChQuote);
      end else if ($urandom_range(0, 7) == 0) begin
        // right at and just past the saturation point
        edge_num = ($urandom_range(0, 1) == 0) ? "2147483647" : "2147483648";
        for (int i = 0; i < edge_num.len(); i++) text_q.push_back(edge_num[i]);
      end else begin
        push_token(1'b1);
      end
      add_blanks(0);
    end
    text_q.push_back(ChClose);
    add_blanks(0);

    // damage some of the objects
    if (mode < 62) return;
    if (mode < 76) begin
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (mode < 88) begin
      cut = $urandom_range(1, text_q.size() - 1);
      while (text_q.size() > cut) void'(text_q.pop_back());
    end else begin
      case ($urandom_range(0, 6))
        0:       text_q.insert($urandom_range(0, text_q.size()), 8'h2D);  // minus
        1:       text_q.insert($urandom_range(0, text_q.size()), ChNul);
        2:       text_q.insert($urandom_range(0, text_q.size()), ChClose);
        3:       text_q.insert($urandom_range(0, text_q.size()), ChComma);
        4:       text_q.insert($urandom_range(0, text_q.size()), ChOpen);
        5:       text_q.insert($urandom_range(0, text_q.size()), ChQuote);
        default: text_q.insert($urandom_range(0, text_q.size()), 8'h78);
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // offer one byte beat and hold it until taken; the expectation is queued on
  // the accepting edge, so valid can go straight on to the next beat
  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    int unsigned gap;
    out_beat_t   guess;
    gap = sender_calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (!in_ready);
    guess = parse_byte(b);
    expected_beats.push_back(typed ? want : guess);
  endtask

  initial begin
    row_t        dir_tab [25];
    in_beat_t    b;
    int unsigned rand_bytes;
    int unsigned texts;

    clear_parse();
    rand_bytes = 0;
    texts      = 0;

    // reset held low from the start, released on an edge
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_tab = '{
      // blank text right after reset: empty
      '{'{ChSpace, 1'b1}, 1'b1, '{EvError, 8'h00, 31'd0, ErrEmpty, 1'b1}},
      // nul where the brace should be
      '{'{ChNul, 1'b1}, 1'b1, '{EvError, 8'h00, 31'd0, ErrNoOpen, 1'b1}},
      // {"a":7,"":9} then a tab: number ended by comma, empty key,
      // number ended by the closing brace, trailing blank
      '{'{ChOpen, 1'b0}, 1'b0, NoCheck},
      '{'{ChQuote, 1'b0}, 1'b0, NoCheck},
      '{'{8'h61, 1'b0}, 1'b0, NoCheck},
      '{'{ChQuote, 1'b0}, 1'b0, NoCheck},
      '{'{ChColon, 1'b0}, 1'b0, NoCheck},
      '{'{ChZero + 8'd7, 1'b0}, 1'b0, NoCheck},
      '{'{ChComma, 1'b0}, 1'b0, NoCheck},
      '{'{ChQuote, 1'b0}, 1'b0, NoCheck},
      '{'{ChQuote, 1'b0}, 1'b0, NoCheck},
      '{'{ChColon, 1'b0}, 1'b0, NoCheck},
      '{'{ChNine, 1'b0}, 1'b0, NoCheck},
      '{'{ChClose, 1'b0}, 1'b0, NoCheck},
      '{'{ChTab, 1'b1}, 1'b0, NoCheck},
      // {"<ff>":"z"}x : top key byte, string value, trailing junk on the last byte
      '{'{ChOpen, 1'b0}, 1'b0, NoCheck},
      '{'{ChQuote, 1'b0}, 1'b0, NoCheck},
      '{'{8'hFF, 1'b0}, 1'b1, '{EvKeyChar, 8'hFF, 31'd0, ErrNone, 1'b0}},
      '{'{ChQuote, 1'b0}, 1'b0, NoCheck},
      '{'{ChColon, 1'b0}, 1'b0, NoCheck},
      '{'{ChQuote, 1'b0}, 1'b0, NoCheck},
      '{'{8'h7A, 1'b0}, 1'b0, NoCheck},
      '{'{ChQuote, 1'b0}, 1'b0, NoCheck},
      '{'{ChClose, 1'b0}, 1'b0, NoCheck},
      '{'{8'h78, 1'b1}, 1'b1, '{EvError, 8'h00, 31'd0, ErrTrailing, 1'b1}}
    };
    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);

    // random texts, each closed by its end-of-text beat
    while (rand_bytes < RandBytes) begin
      build_text();
      texts++;
      // some texts go through with no sender gaps at all
      sender_calm = ($urandom_range(0, 4) == 0);
      if (texts == DrainText) begin
        // sender pauses until the block has handed back everything
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk_i);
      end
      for (int i = 0; i < text_q.size(); i++) begin
        b.text_byte   = text_q[i];
        b.end_of_text = (i == text_q.size() - 1);
        send_beat(b, 1'b0, NoCheck);
        rand_bytes++;
      end
    end
    in_valid <= 1'b0;

    // let the tail drain, then keep the clock running to catch stray beats
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("ran %0d table rows and %0d random texts (%0d bytes); %0d result beats checked",
             $size(dir_tab), texts, rand_bytes, results_seen);
    $display("events: key %0d str %0d key end %0d num %0d str end %0d obj %0d err %0d sat %0d",
             ev_seen[EvKeyChar], ev_seen[EvStrChar], ev_seen[EvKeyEnd], ev_seen[EvNumDone],
             ev_seen[EvStrDone], ev_seen[EvObjDone], ev_seen[EvError], saturated);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // output side: check every accepted result beat, then pick next ready
  // --------------------------------------------------------------------------

  initial begin
    out_beat_t   want;
    int unsigned hold;
    bit          long_done;
    bit          bad;
    hold      = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) begin
        results_seen++;
        ev_seen[out_data.event_res]++;
        if ((out_data.event_res == EvNumDone || out_data.event_res == EvObjDone) &&
            out_data.number_value == NumMax)
          saturated++;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat %0d: ev=%0d ch=%02h num=%0d err=%0d last=%0b",
                     results_seen, out_data.event_res, out_data.char_out,
                     out_data.number_value, out_data.error_code, out_data.last);
        end else begin
          want = expected_beats.pop_front();
          bad  = (out_data.event_res != want.event_res) ||
                 (out_data.char_out != want.char_out) ||
                 (out_data.number_value != want.number_value) ||
                 (out_data.error_code != want.error_code) ||
                 (out_data.last != want.last);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result beat %0d: want ev=%0d ch=%02h num=%0d err=%0d last=%0b",
                       results_seen, want.event_res, want.char_out, want.number_value,
                       want.error_code, want.last);
              $display("result beat %0d: got  ev=%0d ch=%02h num=%0d err=%0d last=%0b",
                       results_seen, out_data.event_res, out_data.char_out,
                       out_data.number_value, out_data.error_code, out_data.last);
            end
          end
        end
      end

      // ready for the next edge: one long hold-off to back up the block,
      // quiet stretches with no stalls, random stalls otherwise
      if (hold != 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!long_done && results_seen >= LongHoldAt) begin
        long_done = 1'b1;
        hold      = LongHold - 1;
        out_ready <= 1'b0;
      end else if ((results_seen / 50) % 4 == 3) begin
        out_ready <= 1'b1;
      end else begin
        hold = idle_len();
        if (hold == 0) begin
          out_ready <= 1'b1;
        end else begin
          hold--;
          out_ready <= 1'b0;
        end
      end
    end
  end

endmodule
